// ===== sv/bucketed_min_score_stack_top_macros.svh =====
// Assertion macros shared by the bucketed score stack RTL.
`ifndef BUCKETED_MIN_SCORE_STACK_TOP_MACROS_SVH
`define BUCKETED_MIN_SCORE_STACK_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check on every clock edge outside reset.
`define BMS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check on every clock edge, reset included.
`define BMS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define BMS_ASSERT(label, prop, msg)
`define BMS_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== sv/bms_pkg.sv =====
// Types and constants of the bucketed score stack.
`timescale 1ns / 1ps
package bms_pkg;

  localparam int NUM_BUCKETS  = 64;
  localparam int BUCKET_DEPTH = 16;
  localparam int SLOTS        = NUM_BUCKETS * BUCKET_DEPTH;

  localparam int BKT_W   = $clog2(NUM_BUCKETS);
  localparam int FILL_W  = $clog2(BUCKET_DEPTH + 1);
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TOT_W   = $clog2(SLOTS + 1);
  localparam int SCORE_W = 18;
  localparam int GRP_N   = (NUM_BUCKETS + 7) / 8;
  localparam int GRP_W   = (GRP_N > 1) ? $clog2(GRP_N) : 1;

  // operation codes
  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // status codes
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // register indexes
  localparam logic [1:0] REG_MM_PEN   = 2'd0;
  localparam logic [1:0] REG_GO_PEN   = 2'd1;
  localparam logic [1:0] REG_GE_PEN   = 2'd2;
  localparam logic [1:0] REG_BKT_USED = 2'd3;

  typedef struct packed {
    logic [15:0] position;
    logic [39:0] interval_low;
    logic [39:0] interval_high;
    logic [7:0]  mismatches;
    logic [7:0]  gap_opens;
    logic [7:0]  gap_extends;
    logic [7:0]  insertions;
    logic [7:0]  deletions;
    logic [1:0]  path_state;
    logic        is_difference;
    logic [31:0] probability;
  } entry_t;

  typedef struct packed {
    logic [1:0] status;
    entry_t     ent;
  } result_t;

endpackage

// ===== sv/bucketed_min_score_stack_top.sv =====
// Top level of the bucketed minimum-score entry stack.
`timescale 1ns / 1ps
`include "bucketed_min_score_stack_top_macros.svh"
// Bucket priority queue of alignment search entries. Each score value owns a
// LIFO bucket of BUCKET_DEPTH slots in one on-chip entry memory. A push word
// gets score = mismatches*mismatch_penalty + gap_opens*gap_open_penalty +
// gap_extends*gap_extend_penalty, worked out by one shared 8x8 multiplier with
// an accumulator in three steps, and lands on top of that score's bucket.
// A push at or above min(buckets_in_use, NUM_BUCKETS) or into a full bucket
// is dropped with status 2. A pop returns the newest word of the lowest
// nonempty bucket, or status 1 when the store is empty; every result that is
// not a successful pop carries zero fields. Operation 2 empties the store at
// once (bucket occupancy lives in a flag vector; the fill counts and entries
// need no clearing pass), operation 3 does nothing and answers done.
// Steps per item, from accept to result registered: a push runs three
// multiply-accumulate steps, the limit check and fill-count read, the slot
// write and the result; a pop the fill-count read, the entry memory read and
// the result; a clear or idle op only the result. When a pop leaves its
// bucket empty the sequencer then walks the occupancy flags eight buckets a
// cycle to find the new best bucket before the next word is taken.
// in_stall_o is high while an item is in work; a finished result waits in
// the output register and does not block the next accept.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i while idle.
module bucketed_min_score_stack_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [15:0] position_i,
  input  logic [39:0] interval_low_i,
  input  logic [39:0] interval_high_i,
  input  logic [7:0]  mismatches_i,
  input  logic [7:0]  gap_opens_i,
  input  logic [7:0]  gap_extends_i,
  input  logic [7:0]  insertions_i,
  input  logic [7:0]  deletions_i,
  input  logic [1:0]  path_state_i,
  input  logic        is_difference_i,
  input  logic [31:0] probability_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [15:0] out_position_o,
  output logic [39:0] out_interval_low_o,
  output logic [39:0] out_interval_high_o,
  output logic [7:0]  out_mismatches_o,
  output logic [7:0]  out_gap_opens_o,
  output logic [7:0]  out_gap_extends_o,
  output logic [7:0]  out_insertions_o,
  output logic [7:0]  out_deletions_o,
  output logic [1:0]  out_path_state_o,
  output logic [15:0] last_difference_position_o,
  output logic [31:0] out_probability_o
);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_CHK   = 3'd2;
  localparam logic [2:0] S_PUSHW = 3'd3;
  localparam logic [2:0] S_POPF  = 3'd4;
  localparam logic [2:0] S_POPD  = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;
  localparam logic [2:0] S_SCAN  = 3'd7;

  localparam int BM_PAD_W = bms_pkg::GRP_N * 8;

  // config registers
  logic [7:0] mm_pen_q, go_pen_q, ge_pen_q;
  logic [6:0] bkt_used_q;

  // control
  logic [2:0]                     state_q;
  logic [1:0]                     step_q;
  logic [bms_pkg::TOT_W-1:0]      total_q;
  logic [bms_pkg::NUM_BUCKETS-1:0] bitmap_q;
  logic [bms_pkg::BKT_W-1:0]      best_q;
  logic                           scan_pend_q;
  logic                           out_valid_q;

  // payload
  logic [1:0]                     op_q;
  bms_pkg::entry_t                item_q;
  logic [bms_pkg::SCORE_W-1:0]    acc_q;
  logic [bms_pkg::BKT_W-1:0]      bkt_q;
  logic [bms_pkg::GRP_W-1:0]      grp_q;
  bms_pkg::result_t               res_q;
  bms_pkg::result_t               out_q;

  // memories
  logic [bms_pkg::FILL_W-1:0] fill_mem [bms_pkg::NUM_BUCKETS];
  logic [bms_pkg::FILL_W-1:0] fill_rd_q;
  bms_pkg::entry_t            ent_mem [bms_pkg::SLOTS];
  bms_pkg::entry_t            ent_rd_q;

  logic                           in_acc;
  logic                           out_free;
  logic [7:0]                     mul_a, mul_b;
  logic [15:0]                    prod;
  logic [bms_pkg::SCORE_W-1:0]    limit;
  logic                           score_ok;
  logic [bms_pkg::FILL_W-1:0]     fill_cur;
  logic                           push_full;
  logic [bms_pkg::SLOT_W-1:0]     slot_w, slot_r;
  logic                           fill_we, fill_re;
  logic [bms_pkg::BKT_W-1:0]      fill_raddr;
  logic [bms_pkg::FILL_W-1:0]     fill_wdata;
  logic [BM_PAD_W-1:0]            bm_pad;
  logic [7:0]                     grp_bits;
  logic [2:0]                     grp_first;
  bms_pkg::entry_t                in_ent;

  function automatic logic [2:0] first_set8(input logic [7:0] v);
    logic [2:0] idx;
    idx = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) idx = 3'(i);
    end
    return idx;
  endfunction

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    in_ent.position      = position_i;
    in_ent.interval_low  = interval_low_i;
    in_ent.interval_high = interval_high_i;
    in_ent.mismatches    = mismatches_i;
    in_ent.gap_opens     = gap_opens_i;
    in_ent.gap_extends   = gap_extends_i;
    in_ent.insertions    = insertions_i;
    in_ent.deletions     = deletions_i;
    in_ent.path_state    = path_state_i;
    in_ent.is_difference = is_difference_i;
    in_ent.probability   = probability_i;
  end

  // shared multiplier: one penalty product per step
  always_comb begin
    unique case (step_q)
      2'd0: begin
        mul_a = item_q.mismatches;
        mul_b = mm_pen_q;
      end
      2'd1: begin
        mul_a = item_q.gap_opens;
        mul_b = go_pen_q;
      end
      default: begin
        mul_a = item_q.gap_extends;
        mul_b = ge_pen_q;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  assign limit = (bkt_used_q < bms_pkg::NUM_BUCKETS) ? bms_pkg::SCORE_W'(bkt_used_q)
                                                     : bms_pkg::SCORE_W'(bms_pkg::NUM_BUCKETS);
  assign score_ok = acc_q < limit;

  // an empty bucket's fill memory entry is stale: read it as zero
  assign fill_cur  = bitmap_q[bkt_q] ? fill_rd_q : '0;
  assign push_full = fill_cur >= bms_pkg::FILL_W'(bms_pkg::BUCKET_DEPTH);
  assign slot_w = bms_pkg::SLOT_W'(bkt_q) * bms_pkg::SLOT_W'(bms_pkg::BUCKET_DEPTH)
                + bms_pkg::SLOT_W'(fill_cur);
  assign slot_r = bms_pkg::SLOT_W'(bkt_q) * bms_pkg::SLOT_W'(bms_pkg::BUCKET_DEPTH)
                + bms_pkg::SLOT_W'(fill_rd_q) - bms_pkg::SLOT_W'(1);

  assign fill_re    = (in_acc && operation_i == bms_pkg::OP_POP && total_q != '0)
                   || (state_q == S_CHK);
  assign fill_raddr = (state_q == S_CHK) ? acc_q[bms_pkg::BKT_W-1:0] : best_q;
  assign fill_we    = (state_q == S_PUSHW && !push_full) || (state_q == S_POPF);
  assign fill_wdata = (state_q == S_PUSHW) ? fill_cur + bms_pkg::FILL_W'(1)
                                           : fill_rd_q - bms_pkg::FILL_W'(1);

  // best-bucket rescan, eight flags per cycle
  assign bm_pad    = BM_PAD_W'(bitmap_q);
  assign grp_bits  = bm_pad[grp_q*8 +: 8];
  assign grp_first = first_set8(grp_bits);

  always_ff @(posedge clk_i) begin
    if (fill_we) fill_mem[bkt_q] <= fill_wdata;
    if (fill_re) fill_rd_q <= fill_mem[fill_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_PUSHW && !push_full) ent_mem[slot_w] <= item_q;
    if (state_q == S_POPF) ent_rd_q <= ent_mem[slot_r];
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mm_pen_q   <= 8'd3;
      go_pen_q   <= 8'd11;
      ge_pen_q   <= 8'd4;
      bkt_used_q <= 7'd64;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bms_pkg::REG_MM_PEN:   mm_pen_q   <= cfg_data_i;
        bms_pkg::REG_GO_PEN:   go_pen_q   <= cfg_data_i;
        bms_pkg::REG_GE_PEN:   ge_pen_q   <= cfg_data_i;
        bms_pkg::REG_BKT_USED: bkt_used_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // sequencer and store bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= 2'd0;
      total_q     <= '0;
      bitmap_q    <= '0;
      best_q      <= '0;
      scan_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_EMIT) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            step_q <= 2'd0;
            if (operation_i == bms_pkg::OP_PUSH) begin
              state_q <= S_MUL;
            end else if (operation_i == bms_pkg::OP_POP && total_q != '0) begin
              state_q <= S_POPF;
            end else begin
              if (operation_i == bms_pkg::OP_CLEAR) begin
                bitmap_q <= '0;
                total_q  <= '0;
              end
              state_q <= S_EMIT;
            end
          end
        end
        S_MUL: begin
          step_q <= step_q + 2'd1;
          if (step_q == 2'd2) state_q <= S_CHK;
        end
        S_CHK: begin
          state_q <= score_ok ? S_PUSHW : S_EMIT;
        end
        S_PUSHW: begin
          if (!push_full) begin
            bitmap_q[bkt_q] <= 1'b1;
            total_q         <= total_q + bms_pkg::TOT_W'(1);
            if (total_q == '0 || best_q > bkt_q) best_q <= bkt_q;
          end
          state_q <= S_EMIT;
        end
        S_POPF: begin
          total_q     <= total_q - bms_pkg::TOT_W'(1);
          scan_pend_q <= (fill_rd_q == bms_pkg::FILL_W'(1))
                      && (total_q != bms_pkg::TOT_W'(1));
          if (fill_rd_q == bms_pkg::FILL_W'(1)) bitmap_q[bkt_q] <= 1'b0;
          state_q <= S_POPD;
        end
        S_POPD: begin
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            if (scan_pend_q) begin
              state_q <= S_SCAN;
            end else begin
              state_q <= S_IDLE;
            end
            scan_pend_q <= 1'b0;
          end
        end
        S_SCAN: begin
          if (grp_bits != 8'd0) begin
            best_q  <= bms_pkg::BKT_W'({grp_q, grp_first});
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= operation_i;
      item_q <= in_ent;
      bkt_q  <= best_q;
      res_q  <= '{status: (operation_i == bms_pkg::OP_POP && total_q == '0)
                          ? bms_pkg::ST_EMPTY : bms_pkg::ST_DONE,
                  ent: '0};
    end
    if (state_q == S_MUL) begin
      acc_q <= ((step_q == 2'd0) ? '0 : acc_q) + bms_pkg::SCORE_W'(prod);
    end
    if (state_q == S_CHK) begin
      bkt_q <= acc_q[bms_pkg::BKT_W-1:0];
      if (!score_ok) res_q.status <= bms_pkg::ST_OVERFLOW;
    end
    if (state_q == S_PUSHW && push_full) res_q.status <= bms_pkg::ST_OVERFLOW;
    if (state_q == S_POPF) grp_q <= bms_pkg::GRP_W'(bkt_q >> 3);
    if (state_q == S_POPD && op_q == bms_pkg::OP_POP) res_q.ent <= ent_rd_q;
    if (state_q == S_SCAN) grp_q <= grp_q + bms_pkg::GRP_W'(1);
    if (state_q == S_EMIT && out_free) out_q <= res_q;
  end

  assign out_valid_o                = out_valid_q;
  assign status_o                   = out_q.status;
  assign out_position_o             = out_q.ent.position;
  assign out_interval_low_o         = out_q.ent.interval_low;
  assign out_interval_high_o        = out_q.ent.interval_high;
  assign out_mismatches_o           = out_q.ent.mismatches;
  assign out_gap_opens_o            = out_q.ent.gap_opens;
  assign out_gap_extends_o          = out_q.ent.gap_extends;
  assign out_insertions_o           = out_q.ent.insertions;
  assign out_deletions_o            = out_q.ent.deletions;
  assign out_path_state_o           = out_q.ent.path_state;
  assign last_difference_position_o = out_q.ent.is_difference ? out_q.ent.position : 16'd0;
  assign out_probability_o          = out_q.ent.probability;

  // occupancy flags and entry count agree
  `BMS_ASSERT(a_count_flags, ((total_q == '0) == (bitmap_q == '0)), "count/flags mismatch")
  // idle with entries stored: the best bucket is occupied
  `BMS_ASSERT(a_best_valid, (state_q == S_IDLE && total_q != '0) |-> bitmap_q[best_q], "best bucket empty")
  // a pop only reaches the fill stage on an occupied bucket
  `BMS_ASSERT(a_pop_fill, (state_q == S_POPF) |-> (fill_rd_q != '0), "pop from empty bucket")
  // rescan only runs while something is stored
  `BMS_ASSERT(a_scan_nonempty, (state_q == S_SCAN) |-> (total_q != '0), "rescan on empty store")

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench of the bucketed minimum-score entry stack.
`timescale 1ns / 1ps
module testbench;

  // Operation code 3 is unused by the block: it must answer done and change nothing.
  localparam logic [1:0] OP_NOP = 2'd3;
  // Hard stop, set well above what the slowest legal run needs.
  localparam int CYCLE_LIMIT = 1_000_000;
  // A pop that empties its bucket keeps the sequencer busy with a bucket scan
  // after its result is registered, so idle points wait this long.
  localparam int DRAIN_CYCLES = 24;

  // One input word: the operation plus the entry fields of a push.
  typedef struct packed {
    logic [1:0]      op;
    bms_pkg::entry_t ent;
  } word_t;

  // One result word, laid out as the output ports.
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] position;
    logic [39:0] interval_low;
    logic [39:0] interval_high;
    logic [7:0]  mismatches;
    logic [7:0]  gap_opens;
    logic [7:0]  gap_extends;
    logic [7:0]  insertions;
    logic [7:0]  deletions;
    logic [1:0]  path_state;
    logic [15:0] last_diff;
    logic [31:0] probability;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [7:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  operation_i = '0;
  logic [15:0] position_i = '0;
  logic [39:0] interval_low_i = '0;
  logic [39:0] interval_high_i = '0;
  logic [7:0]  mismatches_i = '0;
  logic [7:0]  gap_opens_i = '0;
  logic [7:0]  gap_extends_i = '0;
  logic [7:0]  insertions_i = '0;
  logic [7:0]  deletions_i = '0;
  logic [1:0]  path_state_i = '0;
  logic        is_difference_i = 1'b0;
  logic [31:0] probability_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [15:0] out_position_o;
  logic [39:0] out_interval_low_o;
  logic [39:0] out_interval_high_o;
  logic [7:0]  out_mismatches_o;
  logic [7:0]  out_gap_opens_o;
  logic [7:0]  out_gap_extends_o;
  logic [7:0]  out_insertions_o;
  logic [7:0]  out_deletions_o;
  logic [1:0]  out_path_state_o;
  logic [15:0] last_difference_position_o;
  logic [31:0] out_probability_o;

  bucketed_min_score_stack_top u_top (
    .clk_i                      (clk_i),
    .rst_ni                     (rst_ni),
    .cfg_we_i                   (cfg_we_i),
    .cfg_idx_i                  (cfg_idx_i),
    .cfg_data_i                 (cfg_data_i),
    .in_valid_i                 (in_valid_i),
    .in_stall_o                 (in_stall_o),
    .operation_i                (operation_i),
    .position_i                 (position_i),
    .interval_low_i             (interval_low_i),
    .interval_high_i            (interval_high_i),
    .mismatches_i               (mismatches_i),
    .gap_opens_i                (gap_opens_i),
    .gap_extends_i              (gap_extends_i),
    .insertions_i               (insertions_i),
    .deletions_i                (deletions_i),
    .path_state_i               (path_state_i),
    .is_difference_i            (is_difference_i),
    .probability_i              (probability_i),
    .out_valid_o                (out_valid_o),
    .out_stall_i                (out_stall_i),
    .status_o                   (status_o),
    .out_position_o             (out_position_o),
    .out_interval_low_o         (out_interval_low_o),
    .out_interval_high_o        (out_interval_high_o),
    .out_mismatches_o           (out_mismatches_o),
    .out_gap_opens_o            (out_gap_opens_o),
    .out_gap_extends_o          (out_gap_extends_o),
    .out_insertions_o           (out_insertions_o),
    .out_deletions_o            (out_deletions_o),
    .out_path_state_o           (out_path_state_o),
    .last_difference_position_o (last_difference_position_o),
    .out_probability_o          (out_probability_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the stack: weights, bucket fill counts, best-bucket pointer
  // and the entry slots. Updated at the moment a word is accepted.
  // ---------------------------------------------------------------------------
  logic [7:0]      pen_mm = 8'd3;
  logic [7:0]      pen_go = 8'd11;
  logic [7:0]      pen_ge = 8'd4;
  logic [6:0]      bkt_used = 7'd64;
  int unsigned     fill_cnt [bms_pkg::NUM_BUCKETS];
  int unsigned     best_bkt = 64;
  int unsigned     entry_total = 0;
  bms_pkg::entry_t slot_mem [bms_pkg::NUM_BUCKETS][bms_pkg::BUCKET_DEPTH];

  outcome_t    pending_results [$];   // expected result words, oldest first
  int          err_cnt = 0;
  int          results_seen = 0;
  int          cycle_cnt = 0;
  bit          calm = 1'b0;           // when set the sender never pauses

  function automatic int unsigned score_of(bms_pkg::entry_t e);
    return 32'(e.mismatches) * 32'(pen_mm) + 32'(e.gap_opens) * 32'(pen_go)
         + 32'(e.gap_extends) * 32'(pen_ge);
  endfunction

  // Scores at or above this are dropped.
  function automatic int unsigned score_limit();
    return (bkt_used < bms_pkg::NUM_BUCKETS) ? 32'(bkt_used) : bms_pkg::NUM_BUCKETS;
  endfunction

  // Applies one accepted word to the shadow stack and returns the result word.
  function automatic outcome_t predict_outcome(word_t w);
    outcome_t        res;
    int unsigned     score;
    int unsigned     b;
    bms_pkg::entry_t e;
    res = '0;
    res.status = bms_pkg::ST_DONE;
    case (w.op)
      bms_pkg::OP_PUSH: begin
        score = score_of(w.ent);
        // short-circuit keeps the fill lookup inside the bucket range
        if (score >= score_limit() || fill_cnt[score] >= bms_pkg::BUCKET_DEPTH) begin
          res.status = bms_pkg::ST_OVERFLOW;
        end else begin
          slot_mem[score][fill_cnt[score]] = w.ent;
          fill_cnt[score]++;
          entry_total++;
          if (entry_total == 1 || best_bkt > score) best_bkt = score;
        end
      end
      bms_pkg::OP_POP: begin
        b = best_bkt;
        if (entry_total == 0 || b >= bms_pkg::NUM_BUCKETS || fill_cnt[b] == 0) begin
          res.status = bms_pkg::ST_EMPTY;
        end else begin
          fill_cnt[b]--;
          entry_total--;
          e = slot_mem[b][fill_cnt[b]];
          res.position      = e.position;
          res.interval_low  = e.interval_low;
          res.interval_high = e.interval_high;
          res.mismatches    = e.mismatches;
          res.gap_opens     = e.gap_opens;
          res.gap_extends   = e.gap_extends;
          res.insertions    = e.insertions;
          res.deletions     = e.deletions;
          res.path_state    = e.path_state;
          res.last_diff     = e.is_difference ? e.position : 16'd0;
          res.probability   = e.probability;
          // rescan all buckets, whatever the current bucket count
          best_bkt = bkt_used;
          for (int i = bms_pkg::NUM_BUCKETS - 1; i >= 0; i--) begin
            if (fill_cnt[i] != 0) best_bkt = i;
          end
        end
      end
      bms_pkg::OP_CLEAR: begin
        foreach (fill_cnt[i]) fill_cnt[i] = 0;
        entry_total = 0;
        best_bkt = bkt_used;
      end
      default: ;
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Pauses: mostly none or short, now and then long.
  // ---------------------------------------------------------------------------
  function automatic int random_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  // Sender: holds the word until taken, then predicts it.
  task automatic send_word(word_t w);
    int gap;
    operation_i     <= w.op;
    position_i      <= w.ent.position;
    interval_low_i  <= w.ent.interval_low;
    interval_high_i <= w.ent.interval_high;
    mismatches_i    <= w.ent.mismatches;
    gap_opens_i     <= w.ent.gap_opens;
    gap_extends_i   <= w.ent.gap_extends;
    insertions_i    <= w.ent.insertions;
    deletions_i     <= w.ent.deletions;
    path_state_i    <= w.ent.path_state;
    is_difference_i <= w.ent.is_difference;
    probability_i   <= w.ent.probability;
    in_valid_i      <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(predict_outcome(w));
    gap = calm ? 0 : random_pause();
    // valid stays up when the next word follows back to back
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Waits until the block has answered everything and finished its bucket scan.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] value);
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    cfg_we_i   <= 1'b1;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
    case (idx)
      bms_pkg::REG_MM_PEN:   pen_mm = value;
      bms_pkg::REG_GO_PEN:   pen_go = value;
      bms_pkg::REG_GE_PEN:   pen_ge = value;
      bms_pkg::REG_BKT_USED: bkt_used = value[6:0];
      default: ;
    endcase
  endtask

  // Stored entries are kept across a reconfiguration on purpose.
  task automatic load_config(logic [7:0] mm, logic [7:0] go, logic [7:0] ge,
                             logic [7:0] used);
    settle();
    write_reg(bms_pkg::REG_MM_PEN, mm);
    write_reg(bms_pkg::REG_GO_PEN, go);
    write_reg(bms_pkg::REG_GE_PEN, ge);
    write_reg(bms_pkg::REG_BKT_USED, used);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------
  function automatic bms_pkg::entry_t random_entry();
    bms_pkg::entry_t e;
    e.position      = 16'($urandom);
    e.interval_low  = {8'($urandom), 32'($urandom)};
    e.interval_high = {8'($urandom), 32'($urandom)};
    e.mismatches    = 8'($urandom);
    e.gap_opens     = 8'($urandom);
    e.gap_extends   = 8'($urandom);
    e.insertions    = 8'($urandom);
    e.deletions     = 8'($urandom);
    e.path_state    = 2'($urandom);
    e.is_difference = 1'($urandom);
    e.probability   = $urandom;
    return e;
  endfunction

  function automatic bms_pkg::entry_t with_counts(bms_pkg::entry_t e, logic [7:0] mm,
                                                  logic [7:0] go, logic [7:0] ge);
    e.mismatches  = mm;
    e.gap_opens   = go;
    e.gap_extends = ge;
    return e;
  endfunction

  // A push whose counts are picked so that the score usually lands in range;
  // a zero weight lets its count run over the full 8 bits.
  function automatic word_t scored_push();
    word_t       w;
    int unsigned lim;
    w.op  = bms_pkg::OP_PUSH;
    w.ent = random_entry();
    lim   = score_limit();
    for (int t = 0; t < 8; t++) begin
      w.ent.mismatches  = (pen_mm == 0) ? 8'($urandom) : 8'($urandom_range(0, lim / pen_mm));
      w.ent.gap_opens   = (pen_go == 0) ? 8'($urandom) : 8'($urandom_range(0, lim / pen_go));
      w.ent.gap_extends = (pen_ge == 0) ? 8'($urandom) : 8'($urandom_range(0, lim / pen_ge));
      if (score_of(w.ent) < lim) break;
    end
    return w;
  endfunction

  // Mix: push_pct pushes (one in ten with raw counts), pops, rare clears and
  // rare unused opcodes.
  function automatic word_t random_word(int push_pct);
    word_t w;
    int    r;
    r = $urandom_range(0, 99);
    w.ent = random_entry();
    if (r < push_pct) begin
      if ($urandom_range(0, 9) == 0) w.op = bms_pkg::OP_PUSH;
      else w = scored_push();
    end else if (r < 97) begin
      w.op = bms_pkg::OP_POP;
    end else if (r < 99) begin
      w.op = bms_pkg::OP_CLEAR;
    end else begin
      w.op = OP_NOP;
    end
    return w;
  endfunction

  task automatic run_random(int n, int push_pct);
    for (int i = 0; i < n; i++) begin
      // now and then a stretch where the sender never pauses
      if (i % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      send_word(random_word(push_pct));
    end
    calm = 1'b0;
  endtask

  task automatic send_op(logic [1:0] op, bms_pkg::entry_t e);
    word_t w;
    w.op  = op;
    w.ent = e;
    send_word(w);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset weights 3/11/4 and 64 buckets. Field extremes, every opcode, score
  // bounds, LIFO order inside a bucket, rescan upward after a pop, clear.
  task automatic test_directed();
    bms_pkg::entry_t ones;
    bms_pkg::entry_t zeros;
    bms_pkg::entry_t a;
    ones  = '1;   // path state 3 rides along here
    zeros = '0;
    send_op(bms_pkg::OP_POP, random_entry());                     // pop on empty store
    send_op(OP_NOP, random_entry());                              // unused opcode
    send_op(bms_pkg::OP_PUSH, with_counts(ones, 8'd0, 8'd0, 8'd0));  // score 0
    send_op(bms_pkg::OP_PUSH, with_counts(ones, 8'd0, 8'd5, 8'd2));  // score 63, top bucket
    send_op(bms_pkg::OP_PUSH, with_counts(ones, 8'd0, 8'd4, 8'd5));  // score 64, out of range
    send_op(bms_pkg::OP_PUSH, with_counts(ones, 8'd255, 8'd255, 8'd255));
    send_op(bms_pkg::OP_PUSH, with_counts(zeros, 8'd1, 8'd0, 8'd0)); // score 3, zero payload
    a = random_entry();
    a.is_difference = 1'b0;                          // position must not show as a difference
    a.position = 16'hffff;
    send_op(bms_pkg::OP_PUSH, with_counts(a, 8'd0, 8'd1, 8'd0));     // score 11
    repeat (4) send_op(bms_pkg::OP_POP, zeros);      // 0, 3, 11, then scan up to 63
    send_op(bms_pkg::OP_POP, zeros);                 // empty again
    send_op(bms_pkg::OP_PUSH, with_counts(random_entry(), 8'd0, 8'd0, 8'd1));
    send_op(bms_pkg::OP_PUSH, with_counts(random_entry(), 8'd0, 8'd0, 8'd1));
    send_op(bms_pkg::OP_POP, zeros);                 // newest of the two
    send_op(bms_pkg::OP_CLEAR, random_entry());      // clear with an entry left
    send_op(bms_pkg::OP_POP, zeros);
    send_op(bms_pkg::OP_PUSH, with_counts(random_entry(), 8'd0, 8'd0, 8'd0));
    send_op(bms_pkg::OP_CLEAR, zeros);
    send_op(bms_pkg::OP_CLEAR, zeros);               // clear on empty store
    send_op(bms_pkg::OP_POP, zeros);
  endtask

  task automatic test_default_weights();
    run_random(300, 60);
  endtask

  // Fewer buckets while old entries still sit in high buckets: pops must still
  // find them, and an emptied store points at the new bucket count.
  task automatic test_shrunk_range();
    load_config(8'd1, 8'd2, 8'd0, 8'd7);
    run_random(200, 45);
  endtask

  // One bucket and zero weights: every push hits bucket 0, which fills up.
  task automatic test_full_buckets();
    load_config(8'd0, 8'd0, 8'd0, 8'd1);
    run_random(250, 75);
  endtask

  // Top weights: only all-zero counts fit.
  task automatic test_extreme_weights();
    load_config(8'd255, 8'd255, 8'd255, 8'd64);
    run_random(150, 55);
  endtask

  task automatic test_mid_weights();
    load_config(8'd0, 8'd1, 8'd0, 8'd30);
    run_random(250, 60);
    load_config(8'd2, 8'd0, 8'd1, 8'd33);
    run_random(250, 60);
  endtask

  task automatic test_random_weights();
    load_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(1, 64)));
    run_random(150, 60);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall spells of random length, with free stretches between that are mostly short, now and then long.
  // ---------------------------------------------------------------------------
  initial begin
    int run;
    @(posedge rst_ni);
    forever begin
      run = random_pause();
      if (run > 0) begin
        out_stall_i <= 1'b1;
        repeat (run) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      if ($urandom_range(0, 99) < 85) repeat ($urandom_range(1, 12)) @(posedge clk_i);
      else repeat ($urandom_range(60, 250)) @(posedge clk_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    err_cnt++;
    if (err_cnt <= 40) $display("ERROR result %0d: %s", results_seen, msg);
  endtask

  task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", what, got, want));
  endtask

  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing outstanding");
      end else begin
        want = pending_results.pop_front();
        check_field("status", status_o, want.status);
        check_field("out_position", out_position_o, want.position);
        check_field("out_interval_low", out_interval_low_o, want.interval_low);
        check_field("out_interval_high", out_interval_high_o, want.interval_high);
        check_field("out_mismatches", out_mismatches_o, want.mismatches);
        check_field("out_gap_opens", out_gap_opens_o, want.gap_opens);
        check_field("out_gap_extends", out_gap_extends_o, want.gap_extends);
        check_field("out_insertions", out_insertions_o, want.insertions);
        check_field("out_deletions", out_deletions_o, want.deletions);
        check_field("out_path_state", out_path_state_o, want.path_state);
        check_field("last_difference_position", last_difference_position_o,
                    want.last_diff);
        check_field("out_probability", out_probability_o, want.probability);
      end
    end
  end

  // Watchdog.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
             pending_results.size());
    $display("** bucketed_min_score_stack_top: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset once, then the tests in turn, then drain and verdict.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_default_weights();
    test_shrunk_range();
    test_full_buckets();
    test_extreme_weights();
    test_mid_weights();
    test_random_weights();
    settle();
    if (err_cnt == 0) begin
      $display("** bucketed_min_score_stack_top: PASSED **");
    end else begin
      $display("** bucketed_min_score_stack_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== bucketed_min_score_stack_top.f =====
+incdir+sv
sv/bms_pkg.sv
sv/bucketed_min_score_stack_top.sv
bench/testbench.sv
